// ===== hw/rtl/ksb_pkg.sv =====
// ----------------------------------------------------------------------------
// ksb_pkg
// Shared constants and types for the shared-buffer stack block: store sizes,
// pointer widths, operation and status codes.
// ----------------------------------------------------------------------------
package ksb_pkg;

   localparam int SLOT_COUNT  = 16;
   localparam int STACK_COUNT = 4;

   // pointer holds slot indexes plus the null value SLOT_COUNT
   localparam int PTR_W       = $clog2(SLOT_COUNT + 1);
   localparam int SLOT_IDX_W  = $clog2(SLOT_COUNT);
   localparam int STACK_IDX_W = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
   localparam int SID_W       = 2;
   localparam int DATA_W      = 32;

   localparam logic [PTR_W-1:0]  NULL_PTR    = PTR_W'(SLOT_COUNT);
   localparam logic [DATA_W-1:0] EMPTY_VALUE = 32'h7FFF_FFFF;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

endpackage

// ===== hw/rtl/k_stacks_shared_buffer.sv =====
// ----------------------------------------------------------------------------
// k_stacks_shared_buffer
// Several LIFO stacks sharing one slot store, with unused slots on a free list.
// ----------------------------------------------------------------------------
// Usage: a request beat is taken when start is high and busy is low. Every
// request gives exactly one response beat, rsp_valid high for one cycle, which
// the receiver must take as it comes. A request passes through an accept cycle
// and an execute cycle: the accept cycle reads the link and value memories
// (synchronous read) while writing back the new link, and the following cycle
// applies the pointer that came out of the link memory; busy is high during
// that execute cycle, so no new request is taken until it is over. The response
// appears in the cycle after that and overlaps the next accept. After reset the
// link memory is initialized by a pass over all SLOT_COUNT slots (one entry per
// cycle), during which busy stays high. A push on a full store, or on a stack
// id that does not exist, reports overflow; a pop on an empty or nonexistent
// stack reports underflow with data 0x7fffffff. Neither changes any state.
module k_stacks_shared_buffer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_type,
   input  logic [ksb_pkg::SID_W-1:0]    req_stack_id,
   input  logic signed [ksb_pkg::DATA_W-1:0] req_push_data,
   output logic                         rsp_valid,
   output logic signed [ksb_pkg::DATA_W-1:0] rsp_pop_data,
   output ksb_pkg::status_type          rsp_status
);
   import ksb_pkg::*;

   typedef enum logic [1:0] {
      S_INIT,
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;

   // slot store: values and links, registered read
   logic [DATA_W-1:0] slot_values [SLOT_COUNT];
   logic [PTR_W-1:0]  slot_links  [SLOT_COUNT];

   // stack heads and free list head live in flops
   logic [PTR_W-1:0]  stack_heads_ff [STACK_COUNT];
   logic [PTR_W-1:0]  free_head_ff;

   logic [SLOT_IDX_W-1:0]  init_cnt_ff;
   logic                   op_ff;
   logic [STACK_IDX_W-1:0] sid_ff;
   logic                   err_ff;
   logic [PTR_W-1:0]       link_rd_ff;
   logic [DATA_W-1:0]      value_rd_ff;

   logic                   rsp_valid_ff;
   logic [DATA_W-1:0]      rsp_data_ff;
   status_type             rsp_status_ff;

   logic                   accept;
   logic                   is_push;
   logic                   sid_ok;
   logic [STACK_IDX_W-1:0] sid_idx;
   logic [PTR_W-1:0]       head_sel;
   logic                   req_err;
   logic                   do_op;
   logic [PTR_W-1:0]       slot_ptr;
   logic [SLOT_IDX_W-1:0]  slot_idx;

   logic                   link_we;
   logic [SLOT_IDX_W-1:0]  link_wa;
   logic [PTR_W-1:0]       link_wd;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && (state_ff == S_IDLE);

   // request decode
   assign is_push  = (req_type == OP_PUSH);
   assign sid_ok   = ({{(32-SID_W){1'b0}}, req_stack_id} < 32'(STACK_COUNT));
   assign sid_idx  = STACK_IDX_W'(req_stack_id);
   assign head_sel = sid_ok ? stack_heads_ff[sid_idx] : NULL_PTR;

   // bad stack id, full store on push, empty stack on pop; corrupt pointers count as null
   always_comb begin
      if (is_push) begin
         req_err = !sid_ok || (free_head_ff >= NULL_PTR);
      end else begin
         req_err = !sid_ok || (head_sel >= NULL_PTR);
      end
   end

   assign do_op    = accept && !req_err;
   assign slot_ptr = is_push ? free_head_ff : head_sel;
   assign slot_idx = slot_ptr[SLOT_IDX_W-1:0];

   // link write port: init pass, or relink of the slot being moved
   always_comb begin
      link_we = 1'b0;
      link_wa = slot_idx;
      link_wd = is_push ? head_sel : free_head_ff;
      if (state_ff == S_INIT) begin
         link_we = 1'b1;
         link_wa = init_cnt_ff;
         link_wd = PTR_W'(init_cnt_ff) + PTR_W'(1);
      end else if (do_op) begin
         link_we = 1'b1;
      end
   end

   // link memory, read-before-write on the same slot
   always_ff @(posedge clock) begin
      if (do_op) begin
         link_rd_ff <= slot_links[slot_idx];
      end
      if (link_we) begin
         slot_links[link_wa] <= link_wd;
      end
   end

   // value memory
   always_ff @(posedge clock) begin
      if (do_op && !is_push) begin
         value_rd_ff <= slot_values[slot_idx];
      end
      if (do_op && is_push) begin
         slot_values[slot_idx] <= req_push_data;
      end
   end

   // sequencer, pointer registers and response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_cnt_ff  <= '0;
         free_head_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < STACK_COUNT; i++) begin
            stack_heads_ff[i] <= NULL_PTR;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_INIT: begin
               init_cnt_ff <= init_cnt_ff + SLOT_IDX_W'(1);
               if (init_cnt_ff == SLOT_IDX_W'(SLOT_COUNT - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  op_ff    <= req_type;
                  sid_ff   <= sid_idx;
                  err_ff   <= req_err;
                  state_ff <= S_EXEC;
                  if (!req_err) begin
                     if (is_push) begin
                        // slot goes in front of the stack
                        stack_heads_ff[sid_idx] <= free_head_ff;
                     end else begin
                        // slot goes back in front of the free list
                        free_head_ff <= head_sel;
                     end
                  end
               end
            end
            S_EXEC: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
               if (err_ff) begin
                  if (op_ff == OP_PUSH) begin
                     rsp_status_ff <= ST_OVERFLOW;
                     rsp_data_ff   <= '0;
                  end else begin
                     rsp_status_ff <= ST_UNDERFLOW;
                     rsp_data_ff   <= EMPTY_VALUE;
                  end
               end else begin
                  rsp_status_ff <= ST_OK;
                  if (op_ff == OP_PUSH) begin
                     // old link of the taken slot is the next free slot
                     free_head_ff <= link_rd_ff;
                     rsp_data_ff  <= '0;
                  end else begin
                     // old link of the popped slot is the new stack head
                     stack_heads_ff[sid_ff] <= link_rd_ff;
                     rsp_data_ff            <= value_rd_ff;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pop_data = rsp_data_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

// ===== bench/k_stacks_shared_buffer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// k_stacks_shared_buffer_tb
// Self-checking bench for the shared-buffer stack block. A scoreboard keeps its
// own copy of the free list, link store and stack heads, predicts the response
// of every accepted request beat and checks each response beat in order.
// Stimulus is a short directed pass followed by random push/pop traffic that
// swings the store between full and empty.
// ----------------------------------------------------------------------------
module k_stacks_shared_buffer_tb;
   import ksb_pkg::*;

   localparam int RANDOM_ITEMS = 1675;
   localparam int IDLE_LIMIT   = 1000;   // cycles with no request beat taken
   localparam int DRAIN_CYCLES = 6;

   typedef logic [PTR_W-1:0] ptr_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] pop_data;
      status_type               status;
   } stack_rsp_type;

   // ------------------------------------------------------------------------
   // scoreboard: mirrors the slot store and checks responses in order
   // ------------------------------------------------------------------------
   class stack_checker;
      logic [DATA_W-1:0] slot_value [SLOT_COUNT];
      ptr_type           slot_link  [SLOT_COUNT];
      ptr_type           stack_head [STACK_COUNT];
      ptr_type           free_head;
      stack_rsp_type     awaited_rsp [$];
      int                errors;
      int                n_push, n_pop, n_overflow, n_underflow;

      function new();
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_value[i] = '0;
            slot_link[i]  = ptr_type'(i + 1);   // last one lands on null
         end
         for (int s = 0; s < STACK_COUNT; s++) stack_head[s] = NULL_PTR;
         free_head = '0;
         errors = 0;
         n_push = 0; n_pop = 0; n_overflow = 0; n_underflow = 0;
      endfunction

      // work out the response of one accepted request beat
      function void note_request(op_type op, logic [SID_W-1:0] sid,
                                 logic signed [DATA_W-1:0] data);
         ptr_type       slot;
         stack_rsp_type rsp;
         rsp.pop_data = '0;
         rsp.status   = ST_OK;
         if (op == OP_PUSH) begin
            n_push++;
            slot = free_head;
            // pointers at or above SLOT_COUNT count as null
            if (sid >= STACK_COUNT || slot >= SLOT_COUNT) begin
               rsp.status = ST_OVERFLOW;
               n_overflow++;
            end else begin
               free_head        = slot_link[slot];
               slot_link[slot]  = stack_head[sid];
               stack_head[sid]  = slot;
               slot_value[slot] = data;
            end
         end else begin
            n_pop++;
            if (sid >= STACK_COUNT || stack_head[sid] >= SLOT_COUNT) begin
               rsp.status   = ST_UNDERFLOW;
               rsp.pop_data = EMPTY_VALUE;
               n_underflow++;
            end else begin
               slot            = stack_head[sid];
               stack_head[sid] = slot_link[slot];
               slot_link[slot] = free_head;
               free_head       = slot;
               rsp.pop_data    = slot_value[slot];
            end
         end
         awaited_rsp.push_back(rsp);
      endfunction

      function void check_response(logic signed [DATA_W-1:0] pop_data,
                                   status_type status);
         stack_rsp_type exp_rsp;
         if (awaited_rsp.size() == 0) begin
            $error("response beat with none awaited: pop_data %0d status %0d",
                   pop_data, status);
            errors++;
            return;
         end
         exp_rsp = awaited_rsp.pop_front();
         if (pop_data !== exp_rsp.pop_data) begin
            $error("pop_data expected %0d actual %0d", exp_rsp.pop_data, pop_data);
            errors++;
         end
         if (status !== exp_rsp.status) begin
            $error("status expected %0d actual %0d", exp_rsp.status, status);
            errors++;
         end
      endfunction

      function int pending();
         return awaited_rsp.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // block under test
   // ------------------------------------------------------------------------
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_type = 1'b0;
   logic [SID_W-1:0]          req_stack_id = '0;
   logic signed [DATA_W-1:0]  req_push_data = '0;
   logic                      rsp_valid;
   logic signed [DATA_W-1:0]  rsp_pop_data;
   status_type                rsp_status;

   k_stacks_shared_buffer DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_stack_id  (req_stack_id),
      .req_push_data (req_push_data),
      .rsp_valid     (rsp_valid),
      .rsp_pop_data  (rsp_pop_data),
      .rsp_status    (rsp_status)
   );

   stack_checker sb = new();

   initial begin
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // monitor: everything sampled at the rising edge, before the edge's
   // nonblocking updates land, so the order of processes does not matter
   // ------------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         // the response of an older beat may share an edge with a new accept
         if (rsp_valid) sb.check_response(rsp_pop_data, rsp_status);
         if (start && !busy)
            sb.note_request(op_type'(req_type), req_stack_id, req_push_data);

         // watchdog: no request beat taken for too long
         if (start && !busy) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("k_stacks_shared_buffer: mismatch");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------

   // present one request beat and return at the edge that takes it; start is
   // left high so a back-to-back beat needs no second assignment this step
   task automatic issue_request(input op_type op, input logic [SID_W-1:0] sid,
                                input logic signed [DATA_W-1:0] data);
      start         <= 1'b1;
      req_type      <= op;
      req_stack_id  <= sid;
      req_push_data <= data;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_for(input int n);
      if (n > 0) begin
         start         <= 1'b0;
         req_push_data <= $urandom();   // bus noise while idle
         repeat (n) @(posedge clock);
      end
   endtask

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // corner values show up often enough to matter
   function automatic logic signed [DATA_W-1:0] pick_data();
      case ($urandom_range(0, 15))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return '0;
         3:       return -1;
         default: return $urandom();
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   logic signed [DATA_W-1:0] corner_vals [8] = '{
      32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, -32'sd1,
      32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_0001, 32'sh8000_0001
   };

   initial begin
      int               push_pct;
      int               focus;
      bit               no_idle;
      op_type           op;
      logic [SID_W-1:0] sid;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // pop on an empty stack straight out of reset
      issue_request(OP_POP, 2'd3, $urandom());
      idle_for(pick_gap());
      // fill every slot, spreading over all stacks, corner values first
      for (int i = 0; i < SLOT_COUNT; i++) begin
         issue_request(OP_PUSH, SID_W'(i % 4),
                       (i < 8) ? corner_vals[i] : $signed($urandom()));
         idle_for(pick_gap());
      end
      // push into a full store
      issue_request(OP_PUSH, 2'd1, 32'sh1234_5678);
      idle_for(pick_gap());
      // unwind part of it, the rest stays for the random phase
      for (int i = 0; i < 7; i++) begin
         issue_request(OP_POP, SID_W'(i % 4), $urandom());
         idle_for(pick_gap());
      end

      // ---- random part ----
      // segments of 64 beats lean toward filling, draining or mixing, so the
      // store keeps crossing between full and empty; some segments run with
      // no gaps and some hammer one stack
      push_pct = 50;
      focus    = 4;
      no_idle  = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) begin
            case ((n / 64) % 3)
               0:       push_pct = 85;
               1:       push_pct = 15;
               default: push_pct = 50;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            focus   = $urandom_range(0, 4);   // 4 means no favorite stack
         end
         op  = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
         sid = (focus < 4 && $urandom_range(0, 1)) ? SID_W'(focus)
                                                   : SID_W'($urandom_range(0, 3));
         issue_request(op, sid, pick_data());
         if (!no_idle) idle_for(pick_gap());
      end
      start <= 1'b0;

      // drain, then give a stray late beat a chance to show up
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d pushes and %0d pops on all %0d stacks",
               sb.n_push, sb.n_pop, STACK_COUNT);
      $display("full-store pushes: %0d, empty-stack pops: %0d",
               sb.n_overflow, sb.n_underflow);
      if (sb.errors == 0) begin
         $display("k_stacks_shared_buffer: match");
      end else begin
         $display("k_stacks_shared_buffer: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/ksb_pkg.sv
hw/rtl/k_stacks_shared_buffer.sv
bench/k_stacks_shared_buffer_tb.sv
